[rtl/tsg_pkg.sv]
// Shared types, register map and constants for the three-voice sound generator.
package tsg_pkg;

  // Register file geometry
  localparam int REGS      = 16;
  localparam int REG_AW    = 4;
  localparam int VOICES    = 3;
  localparam int PRESCALE  = 16;
  localparam int PRE_W     = 4;

  // Register indexes
  localparam logic [REG_AW-1:0] REG_NOISE      = 4'd6;
  localparam logic [REG_AW-1:0] REG_MIXER      = 4'd7;
  localparam logic [REG_AW-1:0] REG_AMP_A      = 4'd8;
  localparam logic [REG_AW-1:0] REG_ENV_FINE   = 4'd11;
  localparam logic [REG_AW-1:0] REG_ENV_COARSE = 4'd12;
  localparam logic [REG_AW-1:0] REG_SHAPE      = 4'd13;

  // Implemented bits of each register
  localparam logic [7:0] REG_MASK [REGS] = '{
    8'hFF, 8'h0F, 8'hFF, 8'h0F, 8'hFF, 8'h0F, 8'h1F, 8'hFF,
    8'h1F, 8'h1F, 8'h1F, 8'hFF, 8'hFF, 8'h0F, 8'hFF, 8'hFF
  };

  // Envelope shapes that decide the second-segment direction
  localparam logic [3:0] SHAPE_DOWN_REP  = 4'd8;
  localparam logic [3:0] SHAPE_SAW_ALT   = 4'd10;
  localparam logic [3:0] SHAPE_DOWN_HIGH = 4'd11;
  localparam logic [3:0] SHAPE_UP_REP    = 4'd12;
  localparam logic [3:0] SHAPE_UP_HIGH   = 4'd13;
  localparam logic [3:0] SHAPE_TRI_ALT   = 4'd14;

  // Minimum audible tone period
  localparam logic [11:0] TONE_MIN_AUDIBLE = 12'd8;

  // Request kinds on the input side
  typedef enum logic [1:0] {
    FUNC_SELECT = 2'd0,
    FUNC_WRITE  = 2'd1,
    FUNC_READ   = 2'd2,
    FUNC_TICK   = 2'd3
  } func_t;

  // Result kinds on the output side
  localparam logic KIND_READ   = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  // Result payload packed into tdata
  typedef struct packed {
    logic       pad;
    logic [2:0] voice_on;
    logic [3:0] level_c;
    logic [3:0] level_b;
    logic [3:0] level_a;
    logic [7:0] read_data;
  } result_t;

endpackage

[rtl/three_voice_sound_generator.sv]
// Top level of the three-voice square-wave sound generator.
// A read or sample result is registered and presented in the cycle after its request is accepted.
// Throughput: one request per cycle; the single output register is the only stall point,
// and s_tready stays high while that register is empty or being taken.
// Select, write and ticks that do not end a sample period produce no result.
// Reset (rst, synchronous) clears all generator state; register 7 resets to 0xFF.
module three_voice_sound_generator (
  input  logic        clk,
  input  logic        rst,
  // configuration: cycles_per_sample
  input  logic        cfg_wen,
  input  logic [15:0] cfg_wdata,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data
  input  logic [1:0]  s_tuser,   // [1:0] func
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] read_data, [11:8] level_a, [15:12] level_b,
                                 // [19:16] level_c, [22:20] voice_on, [23] zero
  output logic        m_tuser    // [0] kind
);
  import tsg_pkg::*;

  // State
  logic [15:0]       cycles_per_sample;
  logic [7:0]        reg_file [REGS];
  logic [REG_AW-1:0] sel;
  logic [11:0]       tone_count [VOICES];
  logic [VOICES-1:0] square_level;
  logic [PRE_W-1:0]  prescale_count;
  logic [5:0]        noise_count;
  logic [16:0]       noise_lfsr;
  logic [16:0]       env_count;
  logic [4:0]        env_step;
  logic [3:0]        env_level;
  logic              env_second;
  logic [15:0]       sample_count;

  // Next values
  logic [7:0]        reg_file_next [REGS];
  logic [REG_AW-1:0] sel_next;
  logic [11:0]       tone_count_next [VOICES];
  logic [VOICES-1:0] square_level_next;
  logic [PRE_W-1:0]  prescale_count_next;
  logic [5:0]        noise_count_next;
  logic [16:0]       noise_lfsr_next;
  logic [16:0]       env_count_next;
  logic [4:0]        env_step_next;
  logic [3:0]        env_level_next;
  logic              env_second_next;
  logic [15:0]       sample_count_next;

  // Tick datapath
  logic              s_accept;
  func_t             in_func;
  logic              pre_fire;
  logic [11:0]       tone_period [VOICES];
  logic [11:0]       tone_inc [VOICES];
  logic [VOICES-1:0] tone_hit;
  logic [VOICES-1:0] square_after;
  logic [4:0]        noise_period;
  logic [5:0]        noise_inc;
  logic              noise_hit;
  logic [16:0]       lfsr_shift;
  logic [16:0]       lfsr_after;
  logic [3:0]        shape;
  logic [16:0]       env_limit;
  logic [16:0]       env_inc;
  logic              env_hit;
  logic [3:0]        env_level_stepped;
  logic [4:0]        env_step_inc;
  logic              env_wrap;
  logic              env_second_wrap;
  logic [3:0]        env_level_restart;
  logic [3:0]        env_level_after;
  logic [15:0]       sample_inc;
  logic              sample_emit;
  logic [15:0]       sample_count_tick;
  logic [7:0]        mixer;
  logic [3:0]        level [VOICES];
  logic [VOICES-1:0] voice_on;

  // Result
  logic              res_valid;
  logic              res_kind;
  result_t           res_data;

  assign s_tready = !m_tvalid || m_tready;
  assign s_accept = s_tvalid && s_tready;
  assign in_func  = func_t'(s_tuser);

  // Prescaler
  assign pre_fire = (prescale_count == PRE_W'(PRESCALE - 1));

  // Tone dividers, period clamped to at least one
  always_comb begin
    for (int v = 0; v < VOICES; v++) begin
      tone_period[v] = {reg_file[REG_AW'(2 * v + 1)][3:0], reg_file[REG_AW'(2 * v)]};
      if (tone_period[v] == 12'd0) begin
        tone_period[v] = 12'd1;
      end
      tone_inc[v]     = tone_count[v] + 12'd1;
      tone_hit[v]     = (tone_inc[v] >= tone_period[v]);
      square_after[v] = pre_fire ? (square_level[v] ^ tone_hit[v]) : square_level[v];
    end
  end

  // Noise divider and LFSR
  always_comb begin
    noise_period = reg_file[REG_NOISE][4:0];
    if (noise_period == 5'd0) begin
      noise_period = 5'd1;
    end
  end
  assign noise_inc  = noise_count + 6'd1;
  assign noise_hit  = (noise_inc >= {noise_period, 1'b0});
  assign lfsr_shift = {noise_lfsr[0] ^ noise_lfsr[3], noise_lfsr[16:1]};
  assign lfsr_after = (pre_fire && noise_hit) ? lfsr_shift : noise_lfsr;

  // Envelope generator
  assign shape     = reg_file[REG_SHAPE][3:0];
  assign env_limit = {reg_file[REG_ENV_COARSE], reg_file[REG_ENV_FINE], 1'b0};
  assign env_inc   = env_count + 17'd1;
  assign env_hit   = (env_inc >= env_limit);

  always_comb begin
    env_level_stepped = env_level;
    if (env_step != 5'd0) begin
      if (env_second) begin
        if (shape == SHAPE_SAW_ALT || shape == SHAPE_UP_REP) begin
          env_level_stepped = env_level + 4'd1;
        end else if (shape == SHAPE_DOWN_REP || shape == SHAPE_TRI_ALT) begin
          env_level_stepped = env_level - 4'd1;
        end
      end else if (shape[2]) begin
        env_level_stepped = env_level + 4'd1;
      end else begin
        env_level_stepped = env_level - 4'd1;
      end
    end
  end

  assign env_step_inc    = env_step + 5'd1;
  assign env_wrap        = env_step_inc[4];
  // Continuing shapes without hold flip the segment, all other shapes stay in the second segment
  assign env_second_wrap = (shape[3] && !shape[0]) ? !env_second : 1'b1;

  always_comb begin
    if (env_second_wrap) begin
      env_level_restart = (shape == SHAPE_DOWN_REP || shape == SHAPE_DOWN_HIGH ||
                           shape == SHAPE_UP_HIGH || shape == SHAPE_TRI_ALT) ? 4'hF : 4'h0;
    end else begin
      env_level_restart = shape[2] ? 4'h0 : 4'hF;
    end
  end

  assign env_level_after = (pre_fire && env_hit) ?
                           (env_wrap ? env_level_restart : env_level_stepped) : env_level;

  // Sample counter
  assign sample_inc = sample_count + 16'd1;

  always_comb begin
    if (cycles_per_sample == 16'd0) begin
      sample_emit       = 1'b1;
      sample_count_tick = 16'd0;
    end else if (sample_inc >= cycles_per_sample) begin
      sample_emit       = 1'b1;
      sample_count_tick = sample_inc - cycles_per_sample;
    end else begin
      sample_emit       = 1'b0;
      sample_count_tick = sample_inc;
    end
  end

  // Voice levels and activity from the post-tick state
  assign mixer = reg_file[REG_MIXER];

  always_comb begin
    for (int v = 0; v < VOICES; v++) begin
      level[v]    = reg_file[REG_AMP_A + REG_AW'(v)][4] ? env_level_after :
                    reg_file[REG_AMP_A + REG_AW'(v)][3:0];
      voice_on[v] = (tone_period[v] >= TONE_MIN_AUDIBLE) &&
                    ((!mixer[v] && square_after[v]) || (!mixer[v + VOICES] && lfsr_after[0]));
    end
  end

  // Request decode and next state
  always_comb begin
    reg_file_next       = reg_file;
    sel_next            = sel;
    tone_count_next     = tone_count;
    square_level_next   = square_level;
    prescale_count_next = prescale_count;
    noise_count_next    = noise_count;
    noise_lfsr_next     = noise_lfsr;
    env_count_next      = env_count;
    env_step_next       = env_step;
    env_level_next      = env_level;
    env_second_next     = env_second;
    sample_count_next   = sample_count;
    res_valid           = 1'b0;
    res_kind            = KIND_READ;
    res_data            = '0;

    if (s_accept) begin
      unique case (in_func)
        FUNC_SELECT: begin
          sel_next = s_tdata[REG_AW-1:0];
        end
        FUNC_WRITE: begin
          reg_file_next[sel] = s_tdata & REG_MASK[sel];
          // Shape write restarts the envelope in its first segment
          if (sel == REG_SHAPE) begin
            env_count_next  = 17'd0;
            env_second_next = 1'b0;
            env_step_next   = 5'd0;
            env_level_next  = s_tdata[2] ? 4'h0 : 4'hF;
          end
        end
        FUNC_READ: begin
          res_valid          = 1'b1;
          res_data.read_data = reg_file[sel];
        end
        FUNC_TICK: begin
          prescale_count_next = pre_fire ? '0 : prescale_count + PRE_W'(1);
          if (pre_fire) begin
            for (int v = 0; v < VOICES; v++) begin
              tone_count_next[v] = tone_hit[v] ? 12'd0 : tone_inc[v];
            end
            square_level_next = square_after;
            noise_count_next  = noise_hit ? 6'd0 : noise_inc;
            noise_lfsr_next   = lfsr_after;
            env_count_next    = env_hit ? 17'd0 : env_inc;
            if (env_hit) begin
              env_level_next  = env_level_after;
              env_step_next   = env_wrap ? 5'd0 : env_step_inc;
              env_second_next = env_wrap ? env_second_wrap : env_second;
            end
          end
          sample_count_next = sample_count_tick;
          if (sample_emit) begin
            res_valid         = 1'b1;
            res_kind          = KIND_SAMPLE;
            res_data.level_a  = level[0];
            res_data.level_b  = level[1];
            res_data.level_c  = level[2];
            res_data.voice_on = voice_on;
          end
        end
        default: begin
          sel_next = sel;
        end
      endcase
    end
  end

  // State and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      cycles_per_sample <= 16'd81;
      for (int i = 0; i < REGS; i++) begin
        reg_file[i] <= (REG_AW'(i) == REG_MIXER) ? 8'hFF : 8'h00;
      end
      sel            <= '0;
      for (int v = 0; v < VOICES; v++) begin
        tone_count[v] <= 12'd0;
      end
      square_level   <= '0;
      prescale_count <= '0;
      noise_count    <= 6'd0;
      noise_lfsr     <= 17'd1;
      env_count      <= 17'd0;
      env_step       <= 5'd0;
      env_level      <= 4'd0;
      env_second     <= 1'b0;
      sample_count   <= 16'd0;
      m_tvalid       <= 1'b0;
    end else begin
      if (cfg_wen) begin
        cycles_per_sample <= cfg_wdata;
      end
      reg_file       <= reg_file_next;
      sel            <= sel_next;
      tone_count     <= tone_count_next;
      square_level   <= square_level_next;
      prescale_count <= prescale_count_next;
      noise_count    <= noise_count_next;
      noise_lfsr     <= noise_lfsr_next;
      env_count      <= env_count_next;
      env_step       <= env_step_next;
      env_level      <= env_level_next;
      env_second     <= env_second_next;
      sample_count   <= sample_count_next;
      if (res_valid) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Result payload, no reset needed
  always_ff @(posedge clk) begin
    if (res_valid) begin
      m_tdata <= res_data;
      m_tuser <= res_kind;
    end
  end

endmodule

[verif/tb_three_voice_sound_generator.sv]
// Self-checking testbench for the three-voice sound generator: predicted reads and samples.
module tb_three_voice_sound_generator;
  timeunit 1ns;
  timeprecision 1ps;

  import tsg_pkg::*;

  // Register indexes the package leaves unnamed
  localparam logic [3:0] TONE_A_COARSE = 4'd1;
  localparam logic [3:0] TONE_B_FINE   = 4'd2;
  localparam logic [3:0] TONE_C_FINE   = 4'd4;
  localparam logic [3:0] REG_PORT_B    = 4'd15;

  // Envelope shape bits
  localparam logic [3:0] ENV_HOLD   = 4'h1;
  localparam logic [3:0] ENV_ATTACK = 4'h4;
  localparam logic [3:0] ENV_CONT   = 4'h8;

  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 3000;
  localparam int SETTLE      = 4;

  typedef struct packed {
    logic    kind;
    result_t body;
  } chip_result_t;

  // Shadow of the chip state and the queue of results it owes
  class voice_scoreboard;
    logic [15:0]  sample_period;
    logic [7:0]   regs [REGS];
    logic [3:0]   sel;
    logic [11:0]  tone_cnt [VOICES];
    logic         square [VOICES];
    int unsigned  pre_cnt;
    logic [5:0]   noise_cnt;
    logic [16:0]  lfsr;
    logic [16:0]  env_cnt;
    int unsigned  env_step;
    logic [3:0]   env_lvl;
    logic         env_second;
    logic [15:0]  sample_cnt;
    chip_result_t due_results [$];
    int           errors;
    int           checked;

    function new();
      sample_period = 16'd81;
      foreach (regs[i]) regs[i] = 8'h00;
      regs[REG_MIXER] = 8'hFF;
      sel = '0;
      for (int v = 0; v < VOICES; v++) begin
        tone_cnt[v] = '0;
        square[v] = 1'b0;
      end
      pre_cnt = 0;
      noise_cnt = '0;
      lfsr = 17'd1;
      env_cnt = '0;
      env_step = 0;
      env_lvl = '0;
      env_second = 1'b0;
      sample_cnt = '0;
      errors = 0;
      checked = 0;
    endfunction

    function void set_sample_rate(logic [15:0] val);
      sample_period = val;
    endfunction

    // zero period behaves as one
    function logic [11:0] tone_period(int v);
      logic [11:0] p;
      p = {regs[2*v+1][3:0], regs[2*v]};
      return (p == '0) ? 12'd1 : p;
    endfunction

    function void env_restart();
      logic [3:0] shape;
      shape = regs[REG_SHAPE][3:0];
      env_step = 0;
      if (env_second) begin
        env_lvl = (shape == SHAPE_DOWN_REP || shape == SHAPE_DOWN_HIGH ||
                   shape == SHAPE_UP_HIGH || shape == SHAPE_TRI_ALT) ? 4'hF : 4'h0;
      end else begin
        env_lvl = ((shape & ENV_ATTACK) != 0) ? 4'h0 : 4'hF;
      end
    endfunction

    // advance the dividers on a tick out of the divide-by-16 prescaler
    function void prescaled_tick();
      int unsigned np;
      int unsigned env_limit;
      logic [3:0]  shape;
      for (int v = 0; v < VOICES; v++) begin
        tone_cnt[v] = tone_cnt[v] + 12'd1;
        if (tone_cnt[v] >= tone_period(v)) begin
          tone_cnt[v] = '0;
          square[v] = ~square[v];
        end
      end

      np = 32'(regs[REG_NOISE][4:0]);
      if (np == 0) np = 1;
      noise_cnt = noise_cnt + 6'd1;
      if (noise_cnt >= np * 2) begin
        noise_cnt = '0;
        lfsr = {lfsr[0] ^ lfsr[3], lfsr[16:1]};
      end

      shape = regs[REG_SHAPE][3:0];
      env_cnt = env_cnt + 17'd1;
      env_limit = 32'({regs[REG_ENV_COARSE], regs[REG_ENV_FINE]});
      env_limit = env_limit << 1;
      if (env_cnt >= env_limit) begin
        env_cnt = '0;
        if (env_step != 0) begin
          if (env_second) begin
            if (shape == SHAPE_SAW_ALT || shape == SHAPE_UP_REP)
              env_lvl = env_lvl + 4'd1;
            else if (shape == SHAPE_DOWN_REP || shape == SHAPE_TRI_ALT)
              env_lvl = env_lvl - 4'd1;
          end else if ((shape & ENV_ATTACK) != 0) begin
            env_lvl = env_lvl + 4'd1;
          end else begin
            env_lvl = env_lvl - 4'd1;
          end
        end
        env_step++;
        if (env_step >= 16) begin
          if ((shape & (ENV_CONT | ENV_HOLD)) == ENV_CONT) env_second = ~env_second;
          else env_second = 1'b1;
          env_restart();
        end
      end
    endfunction

    // advance the shadow by one accepted request
    function void note_request(func_t f, logic [7:0] d);
      chip_result_t r;
      logic [3:0]   lv [VOICES];
      logic [7:0]   amp;
      r = '0;
      case (f)
        FUNC_SELECT: begin
          sel = d[3:0];
        end
        FUNC_WRITE: begin
          regs[sel] = d & REG_MASK[sel];
          if (sel == REG_SHAPE) begin
            env_cnt = '0;
            env_second = 1'b0;
            env_restart();
          end
        end
        FUNC_READ: begin
          r.kind = KIND_READ;
          r.body.read_data = regs[sel];
          due_results.push_back(r);
        end
        default: begin
          pre_cnt++;
          if (pre_cnt >= PRESCALE) begin
            pre_cnt -= PRESCALE;
            prescaled_tick();
          end
          if (sample_period == '0) begin
            sample_cnt = '0;
          end else begin
            sample_cnt = sample_cnt + 16'd1;
            if (sample_cnt < sample_period) return;
            sample_cnt = sample_cnt - sample_period;
          end
          r.kind = KIND_SAMPLE;
          for (int v = 0; v < VOICES; v++) begin
            amp = regs[REG_AMP_A + v];
            lv[v] = amp[4] ? env_lvl : amp[3:0];
            if (tone_period(v) >= TONE_MIN_AUDIBLE &&
                ((!regs[REG_MIXER][v] && square[v]) || (!regs[REG_MIXER][v+3] && lfsr[0])))
              r.body.voice_on[v] = 1'b1;
          end
          r.body.level_a = lv[0];
          r.body.level_b = lv[1];
          r.body.level_c = lv[2];
          due_results.push_back(r);
        end
      endcase
    endfunction

    task report(string what, int unsigned got, int unsigned want);
      errors++;
      $display("mismatch at result %0d: %s got 0x%0h, want 0x%0h", checked, what, got, want);
    endtask

    task check_result(logic kind, result_t got);
      chip_result_t want;
      checked++;
      if (due_results.size() == 0) begin
        report("result with none pending, kind", kind, 0);
      end else begin
        want = due_results.pop_front();
        if (kind !== want.kind) report("kind", kind, want.kind);
        if (got.read_data !== want.body.read_data)
          report("read_data", got.read_data, want.body.read_data);
        if (got.level_a !== want.body.level_a) report("level_a", got.level_a, want.body.level_a);
        if (got.level_b !== want.body.level_b) report("level_b", got.level_b, want.body.level_b);
        if (got.level_c !== want.body.level_c) report("level_c", got.level_c, want.body.level_c);
        if (got.voice_on !== want.body.voice_on)
          report("voice_on", got.voice_on, want.body.voice_on);
        if (got.pad !== 1'b0) report("pad bit", got.pad, 0);
      end
    endtask

    task flag_leftovers();
      if (due_results.size() != 0) report("results never produced", due_results.size(), 0);
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wen = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  func_t       s_tuser = FUNC_SELECT;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        m_tuser;

  voice_scoreboard sb;
  bit src_idle_on  = 1'b0;
  bit sink_idle_on = 1'b0;
  bit hold_request = 1'b0;
  int hold_left    = 0;
  int stall_left   = 0;
  int idle_run     = 0;

  three_voice_sound_generator u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // mostly short pauses, now and then a long one
  function automatic int idle_length();
    return ($urandom_range(0, 99) < 8) ? $urandom_range(15, 50) : $urandom_range(1, 3);
  endfunction

  // result side: random stalls plus one long hold-off on demand
  always @(posedge clk) begin
    if (hold_request) begin
      hold_request <= 1'b0;
      hold_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else if (sink_idle_on && $urandom_range(0, 3) == 0) begin
      stall_left <= idle_length() - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // compare every taken result
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tuser, result_t'(m_tdata));
  end

  // give up after a long stretch with no progress
  initial begin
    while (idle_run < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wen) idle_run = 0;
      else idle_run++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // one request through the handshake, then an optional pause
  task automatic send_request(func_t f, logic [7:0] d);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata <= d;
    s_tuser <= f;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_request(f, d);
    gap = (src_idle_on && $urandom_range(0, 2) == 0) ? idle_length() : 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // select with junk in the high nibble, then write
  task automatic write_reg(logic [3:0] idx, logic [7:0] val);
    logic [3:0] junk;
    junk = 4'($urandom_range(0, 15));
    send_request(FUNC_SELECT, {junk, idx});
    send_request(FUNC_WRITE, val);
  endtask

  task automatic read_reg(logic [3:0] idx);
    logic [3:0] junk;
    junk = 4'($urandom_range(0, 15));
    send_request(FUNC_SELECT, {junk, idx});
    send_request(FUNC_READ, 8'($urandom_range(0, 255)));
  endtask

  task automatic run_ticks(int n);
    repeat (n) send_request(FUNC_TICK, 8'($urandom_range(0, 255)));
  endtask

  // values that keep tones audible and envelopes moving most of the time
  function automatic logic [7:0] shaped_value(logic [3:0] idx);
    if (idx < REG_NOISE) begin
      if (idx[0]) return 8'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 255) : 0);
      return 8'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(6, 40));
    end
    if (idx == REG_ENV_FINE)
      return 8'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 3));
    if (idx == REG_ENV_COARSE)
      return 8'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : 0);
    return 8'($urandom_range(0, 255));
  endfunction

  // mostly tick runs and select/write or select/read pairs, some raw noise
  task automatic random_mix(int n);
    int done;
    int pick;
    int len;
    logic [3:0] idx;
    done = 0;
    while (done < n) begin
      pick = $urandom_range(0, 99);
      idx = 4'($urandom_range(0, 15));
      if (pick < 55) begin
        len = $urandom_range(1, 12);
        run_ticks(len);
        done += len;
      end else if (pick < 75) begin
        write_reg(idx, shaped_value(idx));
        done += 2;
      end else if (pick < 88) begin
        read_reg(idx);
        done += 2;
      end else if (pick < 93) begin
        send_request(FUNC_READ, 8'($urandom_range(0, 255)));
        done++;
      end else begin
        send_request(func_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        done++;
      end
    end
  endtask

  // stop offering and let every owed result come out
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_sample_rate(logic [15:0] val);
    drain();
    cfg_wen <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_sample_rate(val);
    cfg_wen <= 1'b0;
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // register file corners, no idling
    read_reg(REG_MIXER);
    write_reg(TONE_A_COARSE, 8'hFF);
    send_request(FUNC_READ, 8'h00);
    write_reg(REG_PORT_B, 8'hFF);
    send_request(FUNC_READ, 8'hFF);
    write_reg(TONE_A_COARSE, 8'h00);
    write_reg(TONE_B_FINE, 8'h08);
    write_reg(TONE_C_FINE, 8'h07);
    write_reg(REG_MIXER, 8'h00);
    write_reg(REG_AMP_A, 8'h1F);
    write_reg(REG_AMP_A + 4'd1, 8'h0F);
    write_reg(REG_AMP_A + 4'd2, 8'hE0);
    write_reg(REG_SHAPE, 8'h0E);

    // a full envelope cycle at the reset sample rate
    src_idle_on = 1'b1;
    sink_idle_on = 1'b1;
    run_ticks(280);

    // sample rate extremes, then a drop below the running count
    set_sample_rate(16'd0);
    run_ticks(12);
    set_sample_rate(16'hFFFF);
    run_ticks(20);
    set_sample_rate(16'd200);
    run_ticks(150);
    set_sample_rate(16'd5);
    run_ticks(60);
    set_sample_rate(16'd1);
    random_mix(150);

    // result side holds off while reads keep coming
    hold_request <= 1'b1;
    repeat (20) read_reg(4'($urandom_range(0, 15)));

    for (int phase = 0; phase < 4; phase++) begin
      src_idle_on = (phase % 2) == 1;
      sink_idle_on = phase != 2;
      set_sample_rate(16'($urandom_range(2, 24)));
      random_mix(170);
    end

    drain();
    repeat (8) @(posedge clk);
    sb.flag_leftovers();
    if (sb.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
